[rtl/ffba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, sizes and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // pool and handle table sizes
  localparam int NUM_BLOCKS = 1024;
  localparam int NUM_SLOTS  = 64;
  localparam int TAG_BITS   = 8;

  // transaction field widths
  localparam int FUNC_W   = 3;
  localparam int SIZE_W   = 22;
  localparam int HIDX_W   = 6;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = 10;
  localparam int CNT_W    = 11;
  localparam int SHIFT_W  = 4;
  localparam int REFS_W   = 16;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(3);
  localparam logic [REFS_W-1:0]  REFS_MAX    = {REFS_W{1'b1}};

  // derived pool geometry
  localparam int BLK_AW  = $clog2(NUM_BLOCKS);
  localparam int BLK_CW  = $clog2(NUM_BLOCKS + 1);
  localparam int CALC_W  = SIZE_W + 1;
  localparam int WORD_W  = 8;
  localparam int WORD_AW = $clog2(WORD_W);
  localparam int ROWS    = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIDX_W  = ROW_AW + WORD_AW;

  // derived handle table geometry
  localparam int SLOT_AW  = $clog2(NUM_SLOTS);
  localparam int SLOT_GRP = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int NGRP     = (NUM_SLOTS + SLOT_GRP - 1) / SLOT_GRP;
  localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int GRP_AW   = (SLOT_GRP > 1) ? $clog2(SLOT_GRP) : 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC    = 3'd0,
    FN_REALLOC  = 3'd1,
    FN_FREE     = 3'd2,
    FN_ADD_REF  = 3'd3,
    FN_DROP_REF = 3'd4
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NORUN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;

  typedef enum logic [2:0] {
    RK_ERR,
    RK_NOP,
    RK_ALLOC,
    RK_REALLOC,
    RK_REF,
    RK_FREED
  } res_kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SIZE_W-1:0] byte_size;
    logic [HIDX_W-1:0] handle_index;
    logic [TAG_W-1:0]  handle_tag;
    logic              handle_valid;
    logic              keep_data;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIDX_W-1:0]   out_index;
    logic [TAG_W-1:0]    out_tag;
    logic [OFF_W-1:0]    block_offset;
    logic [CNT_W-1:0]    block_count;
    logic                copy_needed;
    logic [OFF_W-1:0]    old_offset;
    logic [CNT_W-1:0]    old_count;
    logic                freed;
  } out_t;

  // one handle table entry
  typedef struct packed {
    logic [BLK_AW-1:0]   off;
    logic [BLK_CW-1:0]   cnt;
    logic [REFS_W-1:0]   refs;
    logic [TAG_BITS-1:0] tag;
  } slot_entry_t;

  // controller to datapath
  typedef struct packed {
    logic                accept;
    logic                cap_slot;
    logic                scan_start;
    logic                scan_step;
    logic                slot_start;
    logic                slot_step;
    logic                alloc_commit;
    logic                realloc_commit;
    logic                ref_write;
    logic                release_slot;
    logic                mk_start_clr;
    logic                mk_start_set;
    logic                mk_wr;
    logic                mk_set;
    logic                load_out;
    res_kind_t           kind;
    logic [STATUS_W-1:0] status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hv;
    logic              zero;
    logic              over;
    logic              stale;
    logic              drop_zero;
    logic              run_found;
    logic              scan_last;
    logic              slot_found;
    logic              slot_last;
    logic              mk_last;
    logic              out_busy;
  } dp_sts_t;

endpackage

[rtl/ffba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ffba_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: bitmap and handle memories, run scan, slot search,
// run marking and the result register.
// ----------------------------------------------------------------------------
module ffba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffba_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ffba_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::SHIFT_W-1:0]    cfg_wdata,
  input  ffba_pkg::ctrl_cmd_t             cmd,
  output ffba_pkg::dp_sts_t               sts
);

  localparam int RUN_W = ffba_pkg::BLK_CW;
  localparam int AW1   = ffba_pkg::BLK_CW + 1;
  localparam int PADW  = ffba_pkg::NGRP * ffba_pkg::SLOT_GRP;

  // configuration and latched request
  logic [ffba_pkg::SHIFT_W-1:0] shift_r;
  logic [ffba_pkg::FUNC_W-1:0]  func_r;
  logic [ffba_pkg::HIDX_W-1:0]  idx_r;
  logic [ffba_pkg::TAG_W-1:0]   tag_in_r;
  logic                         hv_r;
  logic                         keep_r;
  logic [ffba_pkg::CALC_W-1:0]  cnt_r;
  logic [ffba_pkg::CALC_W-1:0]  cnt_calc;
  logic [ffba_pkg::CALC_W-1:0]  round_add;

  // handle table
  logic [ffba_pkg::NUM_SLOTS-1:0] slot_used_r;
  ffba_pkg::slot_entry_t          old_r;
  ffba_pkg::slot_entry_t          slot_rdata;
  ffba_pkg::slot_entry_t          slot_wdata;
  logic [ffba_pkg::SLOT_AW-1:0]   slot_waddr;
  logic [ffba_pkg::SLOT_AW-1:0]   slot_idx;
  logic                           slot_we;
  logic [ffba_pkg::TAG_BITS-1:0]  next_tag_r;
  logic [ffba_pkg::TAG_BITS-1:0]  next_tag_inc;
  logic [ffba_pkg::TAG_BITS-1:0]  atag_r;
  logic [ffba_pkg::REFS_W-1:0]    refs_new;
  logic                           idx_ok;

  // bitmap
  logic [ffba_pkg::ROWS-1:0]    row_vld_r;
  logic                         rd_vld_r;
  logic [ffba_pkg::ROW_AW-1:0]  bm_raddr;
  logic [ffba_pkg::WORD_W-1:0]  bm_rdata;
  logic [ffba_pkg::WORD_W-1:0]  word;
  logic [ffba_pkg::WORD_W-1:0]  bm_wdata;
  logic [ffba_pkg::WORD_W-1:0]  mk_mask;

  // run scan
  logic [ffba_pkg::ROW_AW-1:0]  ev_row_r;
  logic [RUN_W-1:0]             run_r;
  logic [RUN_W-1:0]             run_nxt;
  logic                         hit;
  logic [ffba_pkg::WORD_AW-1:0] hit_pos;
  logic [AW1-1:0]               found_off;
  logic [ffba_pkg::BLK_AW-1:0]  off_r;

  // slot search
  logic [ffba_pkg::NGRP_W-1:0]   grp_r;
  logic [PADW-1:0]               used_pad;
  logic [ffba_pkg::SLOT_GRP-1:0] grp_bits;
  logic                          sfound;
  logic [ffba_pkg::GRP_AW-1:0]   spos;
  logic [ffba_pkg::SLOT_AW-1:0]  sidx_r;

  // run marking
  logic [ffba_pkg::ROW_AW-1:0]  mk_row_r;
  logic [ffba_pkg::BLK_AW-1:0]  mk_lo_r;
  logic [ffba_pkg::BLK_AW-1:0]  mk_hi_r;
  logic [AW1-1:0]               clr_hi;
  logic [AW1-1:0]               set_hi;

  // result
  logic           out_valid_r;
  ffba_pkg::out_t out_data_r;
  ffba_pkg::out_t res;

  // block count from byte size, rounded up
  always_comb begin
    round_add = (ffba_pkg::CALC_W'(1) << shift_r) - ffba_pkg::CALC_W'(1);
    cnt_calc  = (ffba_pkg::CALC_W'(in_data.byte_size) + round_add) >> shift_r;
  end

  ffba_ram #(
    .WIDTH ($bits(ffba_pkg::slot_entry_t)),
    .DEPTH (ffba_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (ffba_pkg::SLOT_AW'(in_data.handle_index)),
    .rdata (slot_rdata)
  );

  assign slot_idx     = ffba_pkg::SLOT_AW'(idx_r);
  assign idx_ok       = (int'(idx_r) < ffba_pkg::NUM_SLOTS);
  assign next_tag_inc = next_tag_r + ffba_pkg::TAG_BITS'(1);

  always_comb begin
    if (func_r == ffba_pkg::FN_ADD_REF) begin
      refs_new = (old_r.refs == ffba_pkg::REFS_MAX) ? old_r.refs
                                                    : old_r.refs + ffba_pkg::REFS_W'(1);
    end else begin
      refs_new = (old_r.refs == '0) ? old_r.refs : old_r.refs - ffba_pkg::REFS_W'(1);
    end
  end

  always_comb begin
    slot_we    = cmd.alloc_commit | cmd.realloc_commit | cmd.ref_write;
    slot_waddr = cmd.alloc_commit ? sidx_r : slot_idx;
    slot_wdata = old_r;
    if (cmd.alloc_commit) begin
      slot_wdata.off  = off_r;
      slot_wdata.cnt  = RUN_W'(cnt_r);
      slot_wdata.refs = ffba_pkg::REFS_W'(1);
      slot_wdata.tag  = next_tag_r;
    end else if (cmd.realloc_commit) begin
      slot_wdata.off = off_r;
      slot_wdata.cnt = RUN_W'(cnt_r);
    end else begin
      slot_wdata.refs = refs_new;
    end
  end

  // bitmap memory, rows not yet written read as free
  always_comb begin
    if (cmd.scan_start) begin
      bm_raddr = '0;
    end else if (cmd.scan_step) begin
      bm_raddr = ev_row_r + ffba_pkg::ROW_AW'(1);
    end else begin
      bm_raddr = mk_row_r;
    end
  end

  ffba_ram #(
    .WIDTH (ffba_pkg::WORD_W),
    .DEPTH (ffba_pkg::ROWS)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (cmd.mk_wr),
    .waddr (mk_row_r),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign word = rd_vld_r ? bm_rdata : '0;

  // first-fit evaluation of one bitmap row
  always_comb begin
    logic [RUN_W-1:0] r;
    logic             used;
    r       = run_r;
    hit     = 1'b0;
    hit_pos = '0;
    for (int k = 0; k < ffba_pkg::WORD_W; k++) begin
      used = word[k] || ((int'(ev_row_r) * ffba_pkg::WORD_W + k) >= ffba_pkg::NUM_BLOCKS);
      if (!hit) begin
        r = used ? '0 : r + RUN_W'(1);
        if (r == RUN_W'(cnt_r)) begin
          hit     = 1'b1;
          hit_pos = ffba_pkg::WORD_AW'(k);
        end
      end
    end
    run_nxt   = r;
    found_off = AW1'({ev_row_r, hit_pos}) + AW1'(1) - AW1'(cnt_r);
  end

  // lowest free slot in the current group
  always_comb begin
    used_pad = '1;
    used_pad[ffba_pkg::NUM_SLOTS-1:0] = slot_used_r;
    grp_bits = used_pad[grp_r * ffba_pkg::SLOT_GRP +: ffba_pkg::SLOT_GRP];
    sfound   = 1'b0;
    spos     = '0;
    for (int k = 0; k < ffba_pkg::SLOT_GRP; k++) begin
      if (!sfound && !grp_bits[k]) begin
        sfound = 1'b1;
        spos   = ffba_pkg::GRP_AW'(k);
      end
    end
  end

  // run marking mask for the current row
  always_comb begin
    logic [AW1-1:0] b;
    for (int k = 0; k < ffba_pkg::WORD_W; k++) begin
      b = AW1'({mk_row_r, ffba_pkg::WORD_AW'(k)});
      mk_mask[k] = (b >= AW1'(mk_lo_r)) && (b <= AW1'(mk_hi_r));
    end
    bm_wdata = cmd.mk_set ? (word | mk_mask) : (word & ~mk_mask);
  end

  assign clr_hi = AW1'(old_r.off) + AW1'(old_r.cnt) - AW1'(1);
  assign set_hi = AW1'(off_r) + AW1'(cnt_r[RUN_W-1:0]) - AW1'(1);

  // result composition
  always_comb begin
    res        = '0;
    res.status = ffba_pkg::ST_OK;
    unique case (cmd.kind)
      ffba_pkg::RK_ERR: begin
        res.status = cmd.status;
      end
      ffba_pkg::RK_ALLOC: begin
        res.out_index    = ffba_pkg::HIDX_W'(sidx_r);
        res.out_tag      = ffba_pkg::TAG_W'(atag_r);
        res.block_offset = ffba_pkg::OFF_W'(off_r);
        res.block_count  = ffba_pkg::CNT_W'(cnt_r);
      end
      ffba_pkg::RK_REALLOC: begin
        res.out_index    = idx_r;
        res.out_tag      = ffba_pkg::TAG_W'(old_r.tag);
        res.block_offset = ffba_pkg::OFF_W'(off_r);
        res.block_count  = ffba_pkg::CNT_W'(cnt_r);
        res.copy_needed  = keep_r;
        if (keep_r) begin
          res.old_offset = ffba_pkg::OFF_W'(old_r.off);
          res.old_count  = ffba_pkg::CNT_W'(old_r.cnt);
        end
      end
      ffba_pkg::RK_REF, ffba_pkg::RK_FREED: begin
        res.out_index    = idx_r;
        res.out_tag      = ffba_pkg::TAG_W'(old_r.tag);
        res.block_offset = ffba_pkg::OFF_W'(old_r.off);
        res.block_count  = ffba_pkg::CNT_W'(old_r.cnt);
        res.freed        = (cmd.kind == ffba_pkg::RK_FREED);
      end
      default: begin
        res.status = ffba_pkg::ST_OK;
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    sts.func       = func_r;
    sts.hv         = hv_r;
    sts.zero       = (cnt_r == '0);
    sts.over       = (cnt_r > ffba_pkg::CALC_W'(ffba_pkg::NUM_BLOCKS));
    sts.stale      = !(idx_ok && slot_used_r[slot_idx] &&
                       (slot_rdata.tag == ffba_pkg::TAG_BITS'(tag_in_r)));
    sts.drop_zero  = (old_r.refs <= ffba_pkg::REFS_W'(1));
    sts.run_found  = hit;
    sts.scan_last  = (ev_row_r == ffba_pkg::ROW_AW'(ffba_pkg::ROWS - 1));
    sts.slot_found = sfound;
    sts.slot_last  = (grp_r == ffba_pkg::NGRP_W'(ffba_pkg::NGRP - 1));
    sts.mk_last    = (mk_row_r == ffba_pkg::ROW_AW'(mk_hi_r >> ffba_pkg::WORD_AW));
    sts.out_busy   = out_valid_r && !out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= ffba_pkg::SHIFT_RESET;
      slot_used_r <= '0;
      row_vld_r   <= '0;
      next_tag_r  <= ffba_pkg::TAG_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
      if (cmd.alloc_commit) begin
        slot_used_r[sidx_r] <= 1'b1;
        next_tag_r <= (next_tag_inc == '0) ? ffba_pkg::TAG_BITS'(1) : next_tag_inc;
      end
      if (cmd.release_slot) begin
        slot_used_r[slot_idx] <= 1'b0;
      end
      if (cmd.mk_wr) begin
        row_vld_r[mk_row_r] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_vld_r <= (int'(bm_raddr) < ffba_pkg::ROWS) ? row_vld_r[bm_raddr] : 1'b0;
    if (cmd.accept) begin
      func_r   <= in_data.func;
      idx_r    <= in_data.handle_index;
      tag_in_r <= in_data.handle_tag;
      hv_r     <= in_data.handle_valid;
      keep_r   <= in_data.keep_data;
      cnt_r    <= cnt_calc;
    end
    if (cmd.cap_slot) begin
      old_r <= slot_rdata;
    end
    if (cmd.scan_start) begin
      ev_row_r <= '0;
      run_r    <= '0;
    end else if (cmd.scan_step) begin
      ev_row_r <= ev_row_r + ffba_pkg::ROW_AW'(1);
      run_r    <= run_nxt;
      if (hit) begin
        off_r <= ffba_pkg::BLK_AW'(found_off);
      end
    end
    if (cmd.slot_start) begin
      grp_r <= '0;
    end else if (cmd.slot_step) begin
      grp_r <= grp_r + ffba_pkg::NGRP_W'(1);
      if (sfound) begin
        sidx_r <= ffba_pkg::SLOT_AW'(int'(grp_r) * ffba_pkg::SLOT_GRP + int'(spos));
      end
    end
    if (cmd.alloc_commit) begin
      atag_r <= next_tag_r;
    end
    if (cmd.mk_start_clr) begin
      mk_lo_r  <= old_r.off;
      mk_hi_r  <= ffba_pkg::BLK_AW'(clr_hi);
      mk_row_r <= ffba_pkg::ROW_AW'(old_r.off >> ffba_pkg::WORD_AW);
    end else if (cmd.mk_start_set) begin
      mk_lo_r  <= off_r;
      mk_hi_r  <= ffba_pkg::BLK_AW'(set_hi);
      mk_row_r <= ffba_pkg::ROW_AW'(off_r >> ffba_pkg::WORD_AW);
    end else if (cmd.mk_wr) begin
      mk_row_r <= mk_row_r + ffba_pkg::ROW_AW'(1);
    end
    if (cmd.load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ffba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Allocator sequencer: checks, run scan, slot search, marking, result.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffba_pkg::dp_sts_t    sts,
  output ffba_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_REF,
    S_SCAN,
    S_SLOT,
    S_COMMIT,
    S_CLR_RD,
    S_CLR_WR,
    S_SET_RD,
    S_SET_WR,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  ffba_pkg::res_kind_t           kind_r, kind_nxt;
  logic [ffba_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          is_alloc;
  logic                          is_realloc;

  assign is_alloc   = (sts.func == ffba_pkg::FN_ALLOC) ||
                      ((sts.func == ffba_pkg::FN_REALLOC) && !sts.hv);
  assign is_realloc = (sts.func == ffba_pkg::FN_REALLOC) && sts.hv;
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.kind   = kind_r;
    cmd.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.cap_slot = 1'b1;
        kind_nxt     = ffba_pkg::RK_ERR;
        state_nxt    = S_DONE;
        if (is_alloc) begin
          if (sts.zero) begin
            status_nxt = ffba_pkg::ST_ZERO;
          end else if (sts.over) begin
            status_nxt = ffba_pkg::ST_NORUN;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (is_realloc) begin
          if (sts.zero) begin
            status_nxt = ffba_pkg::ST_ZERO;
          end else if (sts.stale) begin
            status_nxt = ffba_pkg::ST_STALE;
          end else if (sts.over) begin
            status_nxt = ffba_pkg::ST_NORUN;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if ((sts.func == ffba_pkg::FN_FREE) || (sts.func == ffba_pkg::FN_ADD_REF) ||
                     (sts.func == ffba_pkg::FN_DROP_REF)) begin
          if (sts.stale) begin
            status_nxt = ffba_pkg::ST_STALE;
          end else begin
            state_nxt = S_REF;
          end
        end else begin
          kind_nxt = ffba_pkg::RK_NOP;
        end
      end
      S_REF: begin
        if ((sts.func == ffba_pkg::FN_FREE) ||
            ((sts.func == ffba_pkg::FN_DROP_REF) && sts.drop_zero)) begin
          cmd.release_slot = 1'b1;
          cmd.mk_start_clr = 1'b1;
          kind_nxt         = ffba_pkg::RK_FREED;
          state_nxt        = S_CLR_RD;
        end else begin
          cmd.ref_write = 1'b1;
          kind_nxt      = ffba_pkg::RK_REF;
          state_nxt     = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.run_found) begin
          if (is_alloc) begin
            cmd.slot_start = 1'b1;
            state_nxt      = S_SLOT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end else if (sts.scan_last) begin
          kind_nxt   = ffba_pkg::RK_ERR;
          status_nxt = ffba_pkg::ST_NORUN;
          state_nxt  = S_DONE;
        end
      end
      S_SLOT: begin
        cmd.slot_step = 1'b1;
        if (sts.slot_found) begin
          state_nxt = S_COMMIT;
        end else if (sts.slot_last) begin
          kind_nxt   = ffba_pkg::RK_ERR;
          status_nxt = ffba_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end
      end
      S_COMMIT: begin
        if (is_alloc) begin
          cmd.alloc_commit = 1'b1;
          cmd.mk_start_set = 1'b1;
          kind_nxt         = ffba_pkg::RK_ALLOC;
          state_nxt        = S_SET_RD;
        end else begin
          // old run goes first, new run was found while it was still used
          cmd.mk_start_clr = 1'b1;
          kind_nxt         = ffba_pkg::RK_REALLOC;
          state_nxt        = S_CLR_RD;
        end
      end
      S_CLR_RD: begin
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd.mk_wr = 1'b1;
        if (!sts.mk_last) begin
          state_nxt = S_CLR_RD;
        end else if (kind_r == ffba_pkg::RK_REALLOC) begin
          cmd.realloc_commit = 1'b1;
          cmd.mk_start_set   = 1'b1;
          state_nxt          = S_SET_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SET_RD: begin
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.mk_wr  = 1'b1;
        cmd.mk_set = 1'b1;
        state_nxt  = sts.mk_last ? S_DONE : S_SET_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kind_r   <= ffba_pkg::RK_NOP;
      status_r <= ffba_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

[rtl/first_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit block pool allocator with reference-counted, tagged handles.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and gives exactly one result. The used
// bitmap sits in a RAM of 8-block rows; allocate and reallocate scan it
// first-fit, one row per cycle up to the pool's 128 rows, until the run is
// known; allocate then searches the handle table for a free slot, and each
// bitmap row touched by a run that is released or marked is read, then
// written. Free and drop release their rows the same way. A result waits in
// an output register, and the next transaction can be accepted while it does.
// No clearing pass is needed after reset: bitmap rows carry valid flags.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ffba_pkg::in_t                 in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output ffba_pkg::out_t                out_data,
  // block size register
  input  logic                          cfg_we,
  input  logic [ffba_pkg::SHIFT_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  ffba_pkg::ctrl_cmd_t cmd;
  ffba_pkg::dp_sts_t   sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit block allocator against a behavioral pool model:
// directed cases for each operation and error, then random mixes of
// allocate, reallocate, free and reference traffic under several block sizes.
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ffba_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffba_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [ffba_pkg::SHIFT_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // pool model state
  logic [ffba_pkg::SHIFT_W-1:0] blk_shift;
  bit pool_used [ffba_pkg::NUM_BLOCKS];
  bit hnd_live [ffba_pkg::NUM_SLOTS];
  int unsigned hnd_off [ffba_pkg::NUM_SLOTS];
  int unsigned hnd_cnt [ffba_pkg::NUM_SLOTS];
  int unsigned hnd_refs [ffba_pkg::NUM_SLOTS];
  logic [ffba_pkg::TAG_W-1:0] hnd_tag [ffba_pkg::NUM_SLOTS];
  logic [ffba_pkg::TAG_W-1:0] tag_next;

  ffba_pkg::out_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  int recv_hold = 0;

  localparam int CYCLE_LIMIT = 5000000;

  task automatic model_reset();
    blk_shift = ffba_pkg::SHIFT_RESET;
    for (int i = 0; i < ffba_pkg::NUM_BLOCKS; i++) pool_used[i] = 1'b0;
    for (int i = 0; i < ffba_pkg::NUM_SLOTS; i++) begin
      hnd_live[i] = 1'b0;
      hnd_tag[i] = '0;
    end
    tag_next = ffba_pkg::TAG_W'(1);
  endtask

  function automatic void mark_blocks(int unsigned off, int unsigned cnt, bit v);
    for (int unsigned i = 0; i < cnt; i++)
      if (off + i < ffba_pkg::NUM_BLOCKS) pool_used[off + i] = v;
  endfunction

  // lowest free run of cnt blocks, -1 if none
  function automatic int first_fit(longint unsigned cnt);
    int run;
    run = 0;
    if (cnt == 0 || cnt > ffba_pkg::NUM_BLOCKS) return -1;
    for (int i = 0; i < ffba_pkg::NUM_BLOCKS; i++) begin
      if (pool_used[i]) run = 0;
      else begin
        run++;
        if (run == cnt) return i + 1 - run;
      end
    end
    return -1;
  endfunction

  function automatic ffba_pkg::out_t release_handle(int s);
    ffba_pkg::out_t r;
    r = '0;
    mark_blocks(hnd_off[s], hnd_cnt[s], 1'b0);
    hnd_live[s] = 1'b0;
    r.out_index = ffba_pkg::HIDX_W'(s);
    r.out_tag = hnd_tag[s];
    r.block_offset = ffba_pkg::OFF_W'(hnd_off[s]);
    r.block_count = ffba_pkg::CNT_W'(hnd_cnt[s]);
    r.freed = 1'b1;
    return r;
  endfunction

  // predicts the result of one transaction and updates the pool model
  function automatic ffba_pkg::out_t predict_alloc(ffba_pkg::in_t t);
    ffba_pkg::out_t r;
    longint unsigned cnt;
    int off, s;
    bit live_ok;
    r = '0;
    cnt = (64'(t.byte_size) + ((64'd1 << blk_shift) - 64'd1)) >> blk_shift;
    live_ok = hnd_live[t.handle_index] && hnd_tag[t.handle_index] == t.handle_tag;
    if (t.func == ffba_pkg::FN_ALLOC ||
        (t.func == ffba_pkg::FN_REALLOC && !t.handle_valid)) begin
      if (cnt == 0) begin r.status = ffba_pkg::ST_ZERO; return r; end
      off = first_fit(cnt);
      if (off < 0) begin r.status = ffba_pkg::ST_NORUN; return r; end
      s = -1;
      for (int i = ffba_pkg::NUM_SLOTS - 1; i >= 0; i--) if (!hnd_live[i]) s = i;
      if (s < 0) begin r.status = ffba_pkg::ST_FULL; return r; end
      hnd_live[s] = 1'b1;
      hnd_off[s] = unsigned'(off);
      hnd_cnt[s] = 32'(cnt);
      hnd_refs[s] = 1;
      hnd_tag[s] = tag_next;
      tag_next = ffba_pkg::TAG_W'(tag_next + 1);
      if (tag_next == 0) tag_next = ffba_pkg::TAG_W'(1);
      mark_blocks(unsigned'(off), 32'(cnt), 1'b1);
      r.out_index = ffba_pkg::HIDX_W'(s);
      r.out_tag = hnd_tag[s];
      r.block_offset = ffba_pkg::OFF_W'(off);
      r.block_count = ffba_pkg::CNT_W'(cnt);
      return r;
    end
    if (t.func == ffba_pkg::FN_REALLOC) begin
      if (cnt == 0) begin r.status = ffba_pkg::ST_ZERO; return r; end
      if (!live_ok) begin r.status = ffba_pkg::ST_STALE; return r; end
      // search happens while the old run is still marked
      off = first_fit(cnt);
      if (off < 0) begin r.status = ffba_pkg::ST_NORUN; return r; end
      s = int'(t.handle_index);
      if (t.keep_data) begin
        r.copy_needed = 1'b1;
        r.old_offset = ffba_pkg::OFF_W'(hnd_off[s]);
        r.old_count = ffba_pkg::CNT_W'(hnd_cnt[s]);
      end
      mark_blocks(hnd_off[s], hnd_cnt[s], 1'b0);
      hnd_off[s] = unsigned'(off);
      hnd_cnt[s] = 32'(cnt);
      mark_blocks(unsigned'(off), 32'(cnt), 1'b1);
      r.out_index = ffba_pkg::HIDX_W'(s);
      r.out_tag = hnd_tag[s];
      r.block_offset = ffba_pkg::OFF_W'(off);
      r.block_count = ffba_pkg::CNT_W'(cnt);
      return r;
    end
    if (t.func inside {ffba_pkg::FN_FREE, ffba_pkg::FN_ADD_REF, ffba_pkg::FN_DROP_REF}) begin
      if (!live_ok) begin r.status = ffba_pkg::ST_STALE; return r; end
      s = int'(t.handle_index);
      if (t.func == ffba_pkg::FN_FREE) return release_handle(s);
      if (t.func == ffba_pkg::FN_ADD_REF) begin
        if (hnd_refs[s] < 65535) hnd_refs[s]++;
      end else begin
        if (hnd_refs[s] > 0) hnd_refs[s]--;
        if (hnd_refs[s] == 0) return release_handle(s);
      end
      r.out_index = ffba_pkg::HIDX_W'(s);
      r.out_tag = hnd_tag[s];
      r.block_offset = ffba_pkg::OFF_W'(hnd_off[s]);
      r.block_count = ffba_pkg::CNT_W'(hnd_cnt[s]);
      return r;
    end
    return r; // unknown operation: all zero
  endfunction

  // queues the expected result of an accepted transaction
  function automatic void expect_result(ffba_pkg::out_t r);
    pending_results = {pending_results, r};
  endfunction

  // sends one transaction, predicting it at acceptance
  task automatic send_req(ffba_pkg::in_t t);
    while (send_idle_en && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    expect_result(predict_alloc(t));
    @(negedge clk);
  endtask

  function automatic ffba_pkg::in_t mk_req(logic [ffba_pkg::FUNC_W-1:0] f, int unsigned sz,
                                           int idx, int tg, bit hv, bit kd);
    ffba_pkg::in_t t;
    t.func = f;
    t.byte_size = ffba_pkg::SIZE_W'(sz);
    t.handle_index = ffba_pkg::HIDX_W'(idx);
    t.handle_tag = ffba_pkg::TAG_W'(tg);
    t.handle_valid = hv;
    t.keep_data = kd;
    return t;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // errors and reference ops finish quickly, allow the longest path anyway
    repeat (400) @(negedge clk);
  endtask

  task automatic write_shift(int v);
    cfg_wdata <= ffba_pkg::SHIFT_W'(v);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    blk_shift = ffba_pkg::SHIFT_W'(v);
  endtask

  // random live handle, or a random slot when the tries find none live
  function automatic ffba_pkg::in_t handle_req(logic [ffba_pkg::FUNC_W-1:0] f);
    int idx;
    idx = int'($urandom_range(ffba_pkg::NUM_SLOTS - 1));
    for (int k = 0; k < 8 && !hnd_live[idx]; k++)
      idx = int'($urandom_range(ffba_pkg::NUM_SLOTS - 1));
    return mk_req(f, 1 + $urandom_range(300), idx,
                  ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'(hnd_tag[idx]),
                  1'b1, 1'($urandom_range(1)));
  endfunction

  // result checker
  always @(posedge clk) begin
    ffba_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data !== e) begin
          $display("%0t mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else
      out_ready <= !(recv_idle_en && $urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_req(mk_req(ffba_pkg::FN_ALLOC, 0, 0, 0, 0, 0));             // zero size
    send_req(mk_req(ffba_pkg::FN_ALLOC, 1, 0, 0, 0, 0));
    send_req(mk_req(ffba_pkg::FN_ALLOC, 9, 0, 0, 0, 0));
    send_req(mk_req(ffba_pkg::FN_ALLOC, 22'h3FFFFF, 0, 0, 0, 0));    // oversize
    send_req(mk_req(ffba_pkg::FN_REALLOC, 0, 1, 2, 1, 1));            // zero size on a live handle
    send_req(mk_req(ffba_pkg::FN_REALLOC, 40, 63, 255, 1, 1));        // stale
    send_req(mk_req(ffba_pkg::FN_REALLOC, 40, 0, 1, 1, 1));           // keep data
    send_req(mk_req(ffba_pkg::FN_REALLOC, 8, 1, 2, 1, 0));            // no copy
    send_req(mk_req(ffba_pkg::FN_REALLOC, 16, 5, 7, 0, 1));           // plain allocate
    send_req(mk_req(ffba_pkg::FN_REALLOC, 8192, 0, 1, 1, 0));         // whole pool, no run
    send_req(mk_req(ffba_pkg::FN_ADD_REF, 0, 0, 1, 0, 0));
    send_req(mk_req(ffba_pkg::FN_DROP_REF, 0, 0, 1, 0, 0));
    send_req(mk_req(ffba_pkg::FN_DROP_REF, 0, 0, 1, 0, 0));           // last reference frees
    send_req(mk_req(ffba_pkg::FN_FREE, 0, 1, 2, 0, 0));
    send_req(mk_req(ffba_pkg::FN_FREE, 0, 1, 2, 0, 0));               // stale after free
    send_req(mk_req(3'd5, 22'h2AAAAA, 42, 8'hAA, 1, 1));              // unknown ops
    send_req(mk_req(3'd7, 22'h155555, 21, 8'h55, 0, 0));
    send_req(mk_req(ffba_pkg::FN_ALLOC, 8192, 0, 0, 0, 0));           // whole pool, no run
    send_req(mk_req(ffba_pkg::FN_ALLOC, 1, 0, 0, 0, 0));              // single block fits at the bottom
    send_req(mk_req(ffba_pkg::FN_FREE, 0, 2, 3, 0, 0));
    wait_drained();
  endtask

  // fill the handle table with tiny runs to reach the full-table status
  task automatic test_table_full();
    write_shift(0);
    for (int i = 0; i < ffba_pkg::NUM_SLOTS + 3; i++)
      send_req(mk_req(ffba_pkg::FN_ALLOC, 1, 0, 0, 0, 0));
    for (int i = 0; i < ffba_pkg::NUM_SLOTS; i++)
      if (hnd_live[i]) send_req(mk_req(ffba_pkg::FN_FREE, 0, i, int'(hnd_tag[i]), 0, 0));
    wait_drained();
  endtask

  task automatic test_random(int n, int shift);
    ffba_pkg::in_t t;
    int r;
    write_shift(shift);
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(99));
      if (r < 30) t = mk_req(ffba_pkg::FN_ALLOC, ($urandom_range(19) == 0) ? $urandom :
                             $urandom_range(1 << (shift + 5)), 0, 0, 0, 0);
      else if (r < 45) begin
        t = handle_req(ffba_pkg::FN_REALLOC);
        t.byte_size = ffba_pkg::SIZE_W'($urandom_range(1 << (shift + 5)));
        t.handle_valid = $urandom_range(5) != 0;
      end else if (r < 65) t = handle_req(ffba_pkg::FN_FREE);
      else if (r < 78) t = handle_req(ffba_pkg::FN_ADD_REF);
      else if (r < 93) t = handle_req(ffba_pkg::FN_DROP_REF);
      else t = mk_req(ffba_pkg::FUNC_W'($urandom_range(7)), $urandom, int'($urandom),
                      int'($urandom), 1'($urandom), 1'($urandom));
      send_req(t);
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    fork
      recv_hold = 300;
      for (int i = 0; i < 20; i++) send_req(handle_req(ffba_pkg::FN_ADD_REF));
    join
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_random(400, 3);
    test_random(300, 12);
    test_backpressure();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random(300, 0);               // no idling stretch
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    test_random(400, 6);
    test_random(400, 1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
